// ===== rtl/bsd_pkg.sv =====
// Shared types and constants for the box signed distance unit.
// No dependencies; used by bsd_sqrt_cell and the top level.
package bsd_pkg;

   // Configuration register index width and register map.
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_HALF_X   = 3'd3,
      REG_HALF_Y   = 3'd4,
      REG_HALF_Z   = 3'd5
   } bsd_reg_type;

   // Control that travels alongside each item down the root chain.
   typedef struct packed {
      logic valid;
      logic sat;
   } bsd_ctl_type;

endpackage

// ===== rtl/bsd_if.sv =====
// Valid/ready channel interfaces for query points and distance results.
// No package dependencies; widths follow COORD_BITS.
interface bsd_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

interface bsd_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] distance;
   logic                         saturated;

   modport source (output valid, output distance, output saturated, input ready);
   modport sink   (input valid, input distance, input saturated, output ready);
endinterface

// ===== rtl/bsd_axis.sv =====
// One axis of the front end: q = |p - c| - half, then the square of max(q, 0)
// built from three half-width partial products. Payload only, no reset.
module bsd_axis #(
   parameter int COORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [COORD_BITS-1:0]   point,
   input  logic [COORD_BITS-1:0]   center,
   input  logic [COORD_BITS-2:0]   half,
   output logic [COORD_BITS+1:0]   q,
   output logic [2*COORD_BITS-3:0] sq
);
   localparam int DW   = COORD_BITS + 1;   // difference
   localparam int QW   = COORD_BITS + 2;   // q, signed
   localparam int SW   = COORD_BITS - 1;   // positive q that can be squared
   localparam int LO_W = (SW + 1) / 2;
   localparam int HI_W = SW - LO_W;
   localparam int PW   = 2 * SW;

   logic [DW-1:0]       d_ff, d_in;
   logic [QW-1:0]       q_ff, q_in;
   logic [2*HI_W-1:0]   hh_ff, hh_in;
   logic [HI_W+LO_W-1:0] hl_ff, hl_in;
   logic [2*LO_W-1:0]   ll_ff, ll_in;
   logic [PW-1:0]       sq_ff, sq_in;

   logic [DW-1:0]       mag;
   logic                neg;
   logic                pos;
   logic [SW-1:0]       base;
   logic [HI_W-1:0]     base_hi;
   logic [LO_W-1:0]     base_lo;

   assign d_in = {point[COORD_BITS-1], point} - {center[COORD_BITS-1], center};

   // |d| - half as one add: invert on negative, carry in the +1
   assign neg  = d_ff[DW-1];
   assign mag  = d_ff ^ {DW{neg}};
   assign q_in = QW'(mag) + QW'(neg) - QW'(half);

   // q > 0; an overflowing q is flagged as saturated in the top level
   assign pos     = !q_ff[QW-1] && (q_ff[QW-2:0] != '0);
   assign base    = pos ? q_ff[SW-1:0] : '0;
   assign base_hi = base[SW-1:LO_W];
   assign base_lo = base[LO_W-1:0];

   assign hh_in = (2*HI_W)'(base_hi) * (2*HI_W)'(base_hi);
   assign hl_in = (HI_W+LO_W)'(base_hi) * (HI_W+LO_W)'(base_lo);
   assign ll_in = (2*LO_W)'(base_lo) * (2*LO_W)'(base_lo);

   assign sq_in = {hh_ff, (2*LO_W)'(0)} + (PW'(hl_ff) << (LO_W + 1)) + PW'(ll_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff  <= d_in;
         q_ff  <= q_in;
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         ll_ff <= ll_in;
         sq_ff <= sq_in;
      end
   end

   assign q  = q_ff;
   assign sq = sq_ff;

endmodule

// ===== rtl/bsd_sqrt_cell.sv =====
// One cell of the integer square root chain: resolves one root bit per item.
// Depends on bsd_pkg for the control struct.
module bsd_sqrt_cell #(
   parameter int COORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  bsd_pkg::bsd_ctl_type    up_ctl,
   input  logic [COORD_BITS:0]     up_rem,
   input  logic [COORD_BITS-1:0]   up_root,
   input  logic [2*COORD_BITS-1:0] up_rad,
   input  logic [COORD_BITS-1:0]   up_inside,
   output bsd_pkg::bsd_ctl_type    dn_ctl,
   output logic [COORD_BITS:0]     dn_rem,
   output logic [COORD_BITS-1:0]   dn_root,
   output logic [2*COORD_BITS-1:0] dn_rad,
   output logic [COORD_BITS-1:0]   dn_inside
);
   localparam int N  = COORD_BITS;
   localparam int RW = N + 3;

   bsd_pkg::bsd_ctl_type ctl_ff;
   logic [N:0]     rem_ff, rem_in;
   logic [N-1:0]   root_ff, root_in;
   logic [2*N-1:0] rad_ff, rad_in;
   logic [N-1:0]   inside_ff;

   logic [RW-1:0]  shifted;
   logic [RW-1:0]  trial;
   logic [RW-1:0]  diff;
   logic           take;

   // bring down the next two radicand bits, try (root << 2) | 1
   assign shifted = {up_rem, up_rad[2*N-1:2*N-2]};
   assign trial   = RW'({up_root, 2'b01});
   assign take    = shifted >= trial;
   assign diff    = shifted - trial;

   assign rem_in  = take ? diff[N:0] : shifted[N:0];
   assign root_in = {up_root[N-2:0], take};
   assign rad_in  = {up_rad[2*N-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff    <= rem_in;
         root_ff   <= root_in;
         rad_ff    <= rad_in;
         inside_ff <= up_inside;
      end
   end

   assign dn_ctl    = ctl_ff;
   assign dn_rem    = rem_ff;
   assign dn_root   = root_ff;
   assign dn_rad    = rad_ff;
   assign dn_inside = inside_ff;

endmodule

// ===== rtl/box_signed_distance_unit.sv =====
// Top level of the box signed distance unit.
// Depends on bsd_pkg, bsd_if (channels), bsd_axis and bsd_sqrt_cell.
//
// Usage:
//  - req_ch carries one query point (point_x/y/z, signed fixed point) per item;
//    rsp_ch returns one item per point: distance (negative inside) and
//    saturated, set when the distance clamped to the largest positive value.
//  - Box center and half extents sit in csr registers, written through
//    csr_wr_en / csr_index / csr_wr_data; the user must write them only while
//    no item is in flight, as the unit does not enforce this. Unknown indexes are dropped.
//  - Throughput: one point per cycle, sustained, while rsp_ch keeps up.
//  - Pipeline from accept to rsp_ch.valid: five front-end stages (difference,
//    q, partial products, square/inside term, sum of squares), one root cell
//    per result bit, and the output register. The root chain length sets the
//    latency.
//  - Stall: the output register is backed by a one-entry skid register, so the
//    chain keeps accepting while a result waits; when both are full the whole
//    chain freezes and req_ch.ready drops (ready is a register, not a path
//    from rsp_ch.ready).
//  - Reset (synchronous, active high) empties the pipeline and loads center 0
//    and half extents of 1.0.
module box_signed_distance_unit #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [bsd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]             csr_wr_data,
   bsd_req_if.sink                           req_ch,
   bsd_rsp_if.source                         rsp_ch
);
   localparam int N  = COORD_BITS;
   localparam int QW = N + 2;
   localparam int PW = 2 * (N - 1);
   localparam int SUM_W = 2 * N;
   localparam logic [N-1:0] OUT_MAX    = {1'b0, {(N-1){1'b1}}};
   localparam logic [N-2:0] HALF_RESET = (N-1)'(64'd1 << FRAC_BITS);  // 1.0

   // ---------------------------------------------------------------- config
   logic [N-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [N-2:0] half_x_ff, half_y_ff, half_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         half_x_ff   <= HALF_RESET;
         half_y_ff   <= HALF_RESET;
         half_z_ff   <= HALF_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bsd_pkg::REG_CENTER_X: center_x_ff <= csr_wr_data;
            bsd_pkg::REG_CENTER_Y: center_y_ff <= csr_wr_data;
            bsd_pkg::REG_CENTER_Z: center_z_ff <= csr_wr_data;
            bsd_pkg::REG_HALF_X:   half_x_ff   <= csr_wr_data[N-2:0];
            bsd_pkg::REG_HALF_Y:   half_y_ff   <= csr_wr_data[N-2:0];
            bsd_pkg::REG_HALF_Z:   half_z_ff   <= csr_wr_data[N-2:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------- flow control
   // Whole chain moves together; it only freezes when the skid slot is full.
   logic pipe_en;
   logic accept;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;

   assign pipe_en      = !skid_valid_ff;
   assign req_ch.ready = pipe_en;
   assign accept       = req_ch.valid && pipe_en;

   // valid bits for front-end stages 1..5
   logic [5:1] vld_ff, vld_in;

   assign vld_in = {vld_ff[4:1], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------ front end
   logic [QW-1:0] q_x, q_y, q_z;
   logic [PW-1:0] sq_x, sq_y, sq_z;

   bsd_axis #(.COORD_BITS(N)) u_axis_x (
      .clock(clock), .enable(pipe_en),
      .point(req_ch.point_x), .center(center_x_ff), .half(half_x_ff),
      .q(q_x), .sq(sq_x)
   );

   bsd_axis #(.COORD_BITS(N)) u_axis_y (
      .clock(clock), .enable(pipe_en),
      .point(req_ch.point_y), .center(center_y_ff), .half(half_y_ff),
      .q(q_y), .sq(sq_y)
   );

   bsd_axis #(.COORD_BITS(N)) u_axis_z (
      .clock(clock), .enable(pipe_en),
      .point(req_ch.point_z), .center(center_z_ff), .half(half_z_ff),
      .q(q_z), .sq(sq_z)
   );

   // q above the largest positive distance: bit N or N-1 set on a positive q
   function automatic logic q_over(input logic [QW-1:0] q);
      q_over = !q[QW-1] && (q[QW-2] || q[QW-3]);
   endfunction

   // stage 3: saturation flag, max of x/y
   logic          sat3_ff, sat3_in;
   logic [QW-1:0] max_xy_ff, max_xy_in;
   logic [QW-1:0] q_z3_ff;

   assign sat3_in   = q_over(q_x) || q_over(q_y) || q_over(q_z);
   assign max_xy_in = ($signed(q_x) > $signed(q_y)) ? q_x : q_y;

   // stage 4: interior term min(max(q), 0)
   logic          sat4_ff;
   logic [QW-1:0] max_all;
   logic [N-1:0]  inside4_ff, inside4_in;

   assign max_all    = ($signed(max_xy_ff) > $signed(q_z3_ff)) ? max_xy_ff : q_z3_ff;
   assign inside4_in = max_all[QW-1] ? max_all[N-1:0] : '0;

   // stage 5: sum of squared exterior components
   logic             sat5_ff;
   logic [N-1:0]     inside5_ff;
   logic [SUM_W-1:0] sum5_ff, sum5_in;

   assign sum5_in = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sat3_ff    <= sat3_in;
         max_xy_ff  <= max_xy_in;
         q_z3_ff    <= q_z;
         sat4_ff    <= sat3_ff;
         inside4_ff <= inside4_in;
         sat5_ff    <= sat4_ff;
         inside5_ff <= inside4_ff;
         sum5_ff    <= sum5_in;
      end
   end

   // ------------------------------------------------------------ root chain
   // One cell per root bit, MSB first.
   bsd_pkg::bsd_ctl_type ctl_chain    [0:N];
   logic [N:0]           rem_chain    [0:N];
   logic [N-1:0]         root_chain   [0:N];
   logic [2*N-1:0]       rad_chain    [0:N];
   logic [N-1:0]         inside_chain [0:N];

   assign ctl_chain[0].valid = vld_ff[5];
   assign ctl_chain[0].sat   = sat5_ff;
   assign rem_chain[0]       = '0;
   assign root_chain[0]      = '0;
   assign rad_chain[0]       = sum5_ff;
   assign inside_chain[0]    = inside5_ff;

   for (genvar k = 0; k < N; k++) begin : g_cell
      bsd_sqrt_cell #(.COORD_BITS(N)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (pipe_en),
         .up_ctl    (ctl_chain[k]),
         .up_rem    (rem_chain[k]),
         .up_root   (root_chain[k]),
         .up_rad    (rad_chain[k]),
         .up_inside (inside_chain[k]),
         .dn_ctl    (ctl_chain[k+1]),
         .dn_rem    (rem_chain[k+1]),
         .dn_root   (root_chain[k+1]),
         .dn_rad    (rad_chain[k+1]),
         .dn_inside (inside_chain[k+1])
      );
   end

   // ------------------------------------------------------------ result
   logic         tail_valid;
   logic         tail_take;
   logic         fin_sat;
   logic [N-1:0] fin_dist;
   logic         out_free;

   assign tail_valid = ctl_chain[N].valid;
   assign tail_take  = pipe_en && tail_valid;

   // exterior length >= 2^(N-1) also saturates
   assign fin_sat  = ctl_chain[N].sat || root_chain[N][N-1];
   assign fin_dist = fin_sat ? OUT_MAX : (root_chain[N] + inside_chain[N]);

   logic         out_sat_ff, out_sat_in;
   logic [N-1:0] out_dist_ff, out_dist_in;
   logic         skid_sat_ff, skid_sat_in;
   logic [N-1:0] skid_dist_ff, skid_dist_in;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sat_in    = out_sat_ff;
      out_dist_in   = out_dist_ff;
      skid_valid_in = skid_valid_ff;
      skid_sat_in   = skid_sat_ff;
      skid_dist_in  = skid_dist_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_sat_in    = skid_sat_ff;
            out_dist_in   = skid_dist_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = tail_take;
            out_sat_in   = fin_sat;
            out_dist_in  = fin_dist;
         end
      end else if (tail_take) begin
         // receiver stalled: park the item in the skid slot
         skid_valid_in = 1'b1;
         skid_sat_in   = fin_sat;
         skid_dist_in  = fin_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sat_ff   <= out_sat_in;
      out_dist_ff  <= out_dist_in;
      skid_sat_ff  <= skid_sat_in;
      skid_dist_ff <= skid_dist_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.distance  = out_dist_ff;
   assign rsp_ch.saturated = out_sat_ff;

   // ------------------------------------------------------------ checks
`ifndef SYNTHESIS
   // skid slot only fills behind a held output item
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full with empty output register");

   // a clamped result always carries the largest positive distance
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sat_ff) |-> (out_dist_ff == OUT_MAX))
      else $error("saturated result with wrong distance");

   // a frozen chain keeps its finished root in place
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (!pipe_en && tail_valid) |=> (tail_valid && $stable(root_chain[N])))
      else $error("root chain tail moved while frozen");
`endif

endmodule

// ===== bench/tb_box_signed_distance_unit.sv =====
// Self-checking bench for box_signed_distance_unit: directed and random query
// points, scored against an in-bench distance predictor.
// Needs bsd_pkg, bsd_if and the unit's RTL; reads nothing at run time.
module tb_box_signed_distance_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int HALF_PERIOD_NS  = 1;                // 2 ns clock
   localparam int RESET_CYCLES    = 2;
   localparam int PIPE_LATENCY    = COORD_BITS + 6;   // accept to rsp valid
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT  = 3000;             // cycles with no item moving
   localparam int HOLD_CYCLES     = 400;              // long output hold-off
   localparam int REPORT_CAP      = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int FLOOD_ITEMS     = 90;

   // Register indexes that decode to nothing; writes there must be dropped.
   localparam logic [bsd_pkg::CSR_INDEX_W-1:0] UNMAPPED_IDX_LO = 3'd6;
   localparam logic [bsd_pkg::CSR_INDEX_W-1:0] UNMAPPED_IDX_HI = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type ONE       = 32'sh0001_0000;  // 1.0 in Q16.16
   localparam longint DIST_MAX  = (longint'(1) << (COORD_BITS - 1)) - 1;

   typedef struct packed {
      coord_type distance;
      logic      saturated;
   } distance_result_type;

   // Receiver behavior, re-picked at the end of each random-length stretch.
   typedef enum {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_PERIODIC
   } ready_mode_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [bsd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [COORD_BITS-1:0]           csr_wr_data;

   bsd_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   bsd_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_ch ();

   box_signed_distance_unit #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Shadow copy of the box registers, updated as each write lands.
   coord_type             center_reg [3];
   logic [COORD_BITS-2:0] half_reg   [3];

   // Distances owed by the unit, oldest first.
   distance_result_type pending_distances [$];

   int unsigned error_count     = 0;
   int unsigned points_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned box_settings    = 0;
   int unsigned stall_cycles    = 0;
   int unsigned idle_cycles     = 0;
   int unsigned burst_left      = 0;
   logic        hold_request    = 1'b0;
   logic        hold_active     = 1'b0;

   // ---------------------------------------------------------------------
   // Distance predictor.
   // Per axis q = |p - c| - half, in 64-bit so nothing wraps. Any q past the
   // positive limit clamps right away. Otherwise the exterior length is the
   // floor root of the sum of positive q squared (up to ~2^63.6, so 66-bit
   // squares), and the interior term min(max(q), 0) is added on top.
   // ---------------------------------------------------------------------
   function automatic distance_result_type box_distance(coord_type px, coord_type py,
                                                        coord_type pz);
      coord_type           pt [3];
      longint              q [3];
      longint              offset;
      longint              inner;
      logic [65:0]         sum_sq;
      logic [65:0]         q_wide;
      logic [65:0]         trial_sq;
      logic [32:0]         root;
      logic [32:0]         trial;
      distance_result_type res;

      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      res.saturated = 1'b0;
      res.distance  = '0;
      for (int i = 0; i < 3; i++) begin
         offset = longint'(pt[i]) - longint'(center_reg[i]);
         if (offset < 0) offset = -offset;
         q[i] = offset - longint'(half_reg[i]);
         if (q[i] > DIST_MAX) res.saturated = 1'b1;
      end

      // far outside on one axis alone
      if (res.saturated) begin
         res.distance = coord_type'(DIST_MAX);
         return res;
      end

      sum_sq = '0;
      for (int i = 0; i < 3; i++) begin
         if (q[i] > 0) begin
            q_wide = 66'(q[i]);
            sum_sq = sum_sq + q_wide * q_wide;
         end
      end

      // bitwise floor square root, MSB first
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         trial    = root | (33'd1 << b);
         trial_sq = 66'(trial) * 66'(trial);
         if (trial_sq <= sum_sq) root = trial;
      end

      inner = q[0];
      if (q[1] > inner) inner = q[1];
      if (q[2] > inner) inner = q[2];
      if (inner > 0) inner = 0;

      // exterior length alone can overflow even when each axis fits
      if (root > DIST_MAX) begin
         res.distance  = coord_type'(DIST_MAX);
         res.saturated = 1'b1;
      end else begin
         res.distance = coord_type'(longint'(root) + inner);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard, watchdog and stall counter on one clock edge. Results are
   // checked before new points are queued; the pipe registers every stage
   // between accept and result, so the two never meet on the same item.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      if (error_count <= REPORT_CAP)
         $display("%0t ns: mismatch on %s after %0d results: got %0d, want %0d",
                  $time, what, results_checked, got, want);
   endtask

   always @(posedge clock) begin
      distance_result_type want;
      logic                moved;

      moved = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            if (pending_distances.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_ch.distance, 0);
            end else begin
               want = pending_distances.pop_front();
               if (rsp_ch.distance !== want.distance)
                  report_mismatch("distance", rsp_ch.distance, want.distance);
               if (rsp_ch.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_ch.saturated, want.saturated);
               results_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            pending_distances.push_back(
               box_distance(req_ch.point_x, req_ch.point_y, req_ch.point_z));
            points_accepted++;
         end
         if (req_ch.valid && !req_ch.ready) stall_cycles++;

         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("No item moved for %0d cycles; %0d results still owed.",
                     WATCHDOG_LIMIT, pending_distances.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result-side ready. Modes rotate so stalls land on every pipe phase,
   // with free-running stretches in between. hold_active forces a long
   // hold-off for the back-pressure test.
   // ---------------------------------------------------------------------
   initial begin
      ready_mode_type mode;
      int unsigned    left;

      mode = READY_ALWAYS;
      left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            left = $urandom_range(20, 120);
         end
         left--;
         case (mode)
            READY_ALWAYS:   rsp_ch.ready <= !hold_active;
            READY_COIN:     rsp_ch.ready <= !hold_active && ($urandom_range(0, 1) == 1);
            READY_MOSTLY:   rsp_ch.ready <= !hold_active && ($urandom_range(0, 3) != 0);
            default:        rsp_ch.ready <= !hold_active && (left % 5 != 0);
         endcase
      end
   end

   // Long hold-off, counted here so the sender keeps pushing meanwhile.
   initial begin
      forever begin
         wait (hold_request);
         hold_request = 1'b0;
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one point; returns right after the edge that took it, with valid
   // still high so back-to-back items keep the channel busy. Bursts of
   // random length are separated by random gaps.
   task automatic send_point(input coord_type px, input coord_type py,
                             input coord_type pz);
      int unsigned gap;

      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(60, 160);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 20);
            gap        = $urandom_range(0, 10);
         end
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.point_x <= px;
      req_ch.point_y <= py;
      req_ch.point_z <= pz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every owed distance is back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_distances.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; leaves csr_wr_en high for back-to-back writes.
   task automatic write_box_reg(input logic [bsd_pkg::CSR_INDEX_W-1:0] index,
                                input logic [COORD_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      case (index)
         bsd_pkg::REG_CENTER_X: center_reg[0] = data;
         bsd_pkg::REG_CENTER_Y: center_reg[1] = data;
         bsd_pkg::REG_CENTER_Z: center_reg[2] = data;
         bsd_pkg::REG_HALF_X:   half_reg[0]   = data[COORD_BITS-2:0];
         bsd_pkg::REG_HALF_Y:   half_reg[1]   = data[COORD_BITS-2:0];
         bsd_pkg::REG_HALF_Z:   half_reg[2]   = data[COORD_BITS-2:0];
         default: ;
      endcase
   endtask

   // Full box setup. Half-extent data is raw: bit 31 is junk the unit drops.
   task automatic load_box(input coord_type cx, input coord_type cy,
                           input coord_type cz,
                           input logic [COORD_BITS-1:0] hx,
                           input logic [COORD_BITS-1:0] hy,
                           input logic [COORD_BITS-1:0] hz);
      write_box_reg(bsd_pkg::REG_CENTER_X, cx);
      write_box_reg(bsd_pkg::REG_CENTER_Y, cy);
      write_box_reg(bsd_pkg::REG_CENTER_Z, cz);
      write_box_reg(bsd_pkg::REG_HALF_X, hx);
      write_box_reg(bsd_pkg::REG_HALF_Y, hy);
      write_box_reg(bsd_pkg::REG_HALF_Z, hz);
      csr_wr_en <= 1'b0;
      box_settings++;
   endtask

   function automatic coord_type pick_center();
      case ($urandom_range(0, 5))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return coord_type'($urandom_range(0, 1 << 21)) - coord_type'(1 << 20);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_half();
      logic [COORD_BITS-1:0] data;

      case ($urandom_range(0, 5))
         0:       data = '0;
         1:       data = 32'h7FFF_FFFF;
         2:       data = $urandom_range(0, 1 << 18);
         3:       data = $urandom_range(0, 1 << 26);
         default: data = $urandom & 32'h7FFF_FFFF;
      endcase
      data[COORD_BITS-1] = 1'($urandom_range(0, 1));
      return data;
   endfunction

   // Coordinates cluster around the box surface and inside it, where the
   // interior/exterior split matters; the rest hits extremes or full range.
   function automatic coord_type pick_coord(int axis);
      int unsigned sel;
      longint      span;
      longint      off;
      logic [63:0] wide_rand;

      sel       = $urandom_range(0, 99);
      wide_rand = {$urandom, $urandom};
      if (sel < 60) begin
         if (sel < 40) span = 2 * longint'(half_reg[axis]) + 4 * longint'(ONE);
         else          span = longint'(half_reg[axis]);
         off = longint'(wide_rand[62:0] % (span + 1));
         if ($urandom_range(0, 1) == 1) off = -off;
         return coord_type'(longint'(center_reg[axis]) + off);
      end
      if (sel < 70) begin
         case ($urandom_range(0, 3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return center_reg[axis];
         endcase
      end
      return coord_type'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset box: cube of half size 1.0 at the origin.
   task automatic test_reset_box();
      send_point('0, '0, '0);                          // deep inside: -1.0
      send_point(ONE, '0, '0);                         // on a face: 0
      send_point(2 * ONE, '0, '0);                     // one unit out
      send_point(2 * ONE, 2 * ONE, 2 * ONE);           // corner region, sqrt(3)
      send_point(-2 * ONE, '0, 32'sh0001_8000);        // negative side, mixed
      send_point(COORD_MAX, COORD_MAX, COORD_MAX);     // length overflows
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, '0, '0);                   // largest single-axis reach
      send_point(COORD_MIN, '0, '0);
   endtask

   // Every register, junk in the unused half-extent bit, unmapped indexes.
   task automatic test_register_map();
      drain_results();
      write_box_reg(UNMAPPED_IDX_LO, 32'hDEAD_BEEF);
      write_box_reg(UNMAPPED_IDX_HI, 32'h5555_AAAA);
      load_box(32'sh0003_8000, -32'sh0001_4000, 32'sh1234_5678,
               32'h8000_C000, 32'h0002_0000, 32'hFFFF_0000);
      send_point(32'sh0003_8000, -32'sh0001_4000, 32'sh1234_5678);   // at center
      send_point(32'sh0004_0000, '0, '0);
      send_point(-32'sh0010_0000, 32'sh0002_0000, COORD_MAX);
   endtask

   // Point box at the most negative corner: per-axis overflow, length
   // overflow, and the exact positive limit without clamping.
   task automatic test_far_outside();
      drain_results();
      load_box(COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
      send_point(COORD_MAX, COORD_MIN, COORD_MIN);     // q beyond limit
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);     // on the point: 0
      send_point(COORD_MIN + 3, COORD_MIN + 4, COORD_MIN);
      send_point(-1, -1, COORD_MIN);                   // two max q: root clamps
      send_point(-1, COORD_MIN, COORD_MIN);            // exactly at limit
   endtask

   // Zero half extents: a line along y (half_y written all ones, masked).
   task automatic test_degenerate_box();
      drain_results();
      load_box('0, '0, '0, '0, 32'hFFFF_FFFF, '0);
      send_point('0, 5, '0);
      send_point(3, '0, -4);
      send_point('0, '0, '0);
      send_point(-ONE, COORD_MAX, ONE);
   endtask

   // Random points over several box settings, extremes first.
   task automatic test_random_points();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0:       load_box(COORD_MIN, COORD_MIN, COORD_MIN,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            1:       load_box(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0);
            default: load_box(pick_center(), pick_center(), pick_center(),
                              pick_half(), pick_half(), pick_half());
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_point(pick_coord(0), pick_coord(1), pick_coord(2));
      end
   endtask

   // Hold the output off long enough for the pipe and skid to fill, while
   // points keep coming with no gaps.
   task automatic test_backpressure();
      drain_results();
      load_box(pick_center(), pick_center(), pick_center(),
               pick_half(), pick_half(), pick_half());
      hold_request = 1'b1;
      burst_left   = FLOOD_ITEMS + 1;
      for (int n = 0; n < FLOOD_ITEMS; n++)
         send_point(pick_coord(0), pick_coord(1), pick_coord(2));
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < 3; i++) begin
         center_reg[i] = '0;
         half_reg[i]   = ONE[COORD_BITS-2:0];
      end
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= bsd_pkg::REG_CENTER_X;
      csr_wr_data    <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.point_x <= '0;
      req_ch.point_y <= '0;
      req_ch.point_z <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_box();
      test_register_map();
      test_far_outside();
      test_degenerate_box();
      test_random_points();
      test_backpressure();

      // let any stray extra result show up before scoring
      drain_results();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (pending_distances.size() != 0)
         report_mismatch("distances never returned", pending_distances.size(), 0);

      $display("Sent %0d points across %0d box settings; %0d distances compared.",
               points_accepted, box_settings, results_checked);
      $display("Input held back for %0d cycles by output stalls; %0d mismatches.",
               stall_cycles, error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
